/* design/kmc_pkg.sv */
// Package for the 2D k-means clustering block: sizes, register indexes,
// sequencer states and the result record type. Depends on nothing.
`default_nettype none

package kmc_pkg;

  localparam int MaxPoints   = 32;
  localparam int MaxClusters = 8;
  localparam int CoordBits   = 16;

  localparam int IdxW  = $clog2(MaxPoints);
  localparam int CntW  = $clog2(MaxPoints) + 1;
  localparam int CidW  = $clog2(MaxClusters);
  localparam int KW    = 4;
  localparam int ItW   = 8;
  localparam int SumW  = CoordBits + IdxW + 1;
  localparam int DivW  = SumW - 1;
  localparam int DcW   = $clog2(DivW + 1);
  localparam int SqW   = 2 * CoordBits;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgClusterCount   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIterationCount = 2'd1;

  localparam logic [KW-1:0]  ClusterCountReset   = 4'd3;
  localparam logic [ItW-1:0] IterationCountReset = 8'd10;

  localparam logic KindCenter = 1'b0;
  localparam logic KindPoint  = 1'b1;

  typedef enum logic [3:0] {
    StLoad,
    StInitRd,
    StInitWr,
    StAsgRd,
    StAsgDx,
    StAsgDy,
    StAsgCmp,
    StUpdRd,
    StUpdAcc,
    StUpdChk,
    StDivInit,
    StDivStep,
    StDivDone,
    StOutC,
    StOutRd,
    StOutPt
  } kmc_state_e;

  typedef struct packed {
    logic                        record_kind;
    logic [4:0]                  record_index;
    logic [2:0]                  cluster_id;
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic                        dropped_points;
    logic                        run_end;
  } kmc_rec_t;

endpackage

`default_nettype wire

/* design/kmc_if.sv */
// Handshake channels of the clustering block: point input, result output
// and configuration write. Depends on kmc_pkg.
`default_nettype none

interface kmc_in_if import kmc_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] coord_x;
  logic signed [CoordBits-1:0] coord_y;
  logic                        final_point;
  modport source (output valid, coord_x, coord_y, final_point, input ready);
  modport sink (input valid, coord_x, coord_y, final_point, output ready);
endinterface

interface kmc_out_if import kmc_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        record_kind;
  logic [4:0]                  record_index;
  logic [2:0]                  cluster_id;
  logic signed [CoordBits-1:0] out_x;
  logic signed [CoordBits-1:0] out_y;
  logic                        dropped_points;
  logic                        run_end;
  modport source (output valid, record_kind, record_index, cluster_id, out_x, out_y,
                  dropped_points, run_end, input ready);
  modport sink (input valid, record_kind, record_index, cluster_id, out_x, out_y,
                dropped_points, run_end, output ready);
endinterface

interface kmc_cfg_if import kmc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/kmc_point_mem.sv */
// Point store of the clustering block: coordinates and cluster assignment
// per point, one shared registered read port. Depends on kmc_pkg.
`default_nettype none

module kmc_point_mem import kmc_pkg::*; (
  input  wire logic                        clk_i,
  input  wire logic                        pt_we_i,
  input  wire logic [IdxW-1:0]             pt_waddr_i,
  input  wire logic signed [CoordBits-1:0] pt_x_i,
  input  wire logic signed [CoordBits-1:0] pt_y_i,
  input  wire logic                        cl_we_i,
  input  wire logic [IdxW-1:0]             cl_waddr_i,
  input  wire logic [CidW-1:0]             cl_i,
  input  wire logic [IdxW-1:0]             raddr_i,
  output      logic signed [CoordBits-1:0] rd_x_o,
  output      logic signed [CoordBits-1:0] rd_y_o,
  output      logic [CidW-1:0]             rd_cl_o
);

  logic [2*CoordBits-1:0] pt_mem [MaxPoints];
  logic [CidW-1:0]        cl_mem [MaxPoints];

  always_ff @(posedge clk_i) begin
    if (pt_we_i) begin
      pt_mem[pt_waddr_i] <= {pt_x_i, pt_y_i};
    end
    {rd_x_o, rd_y_o} <= pt_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cl_we_i) begin
      cl_mem[cl_waddr_i] <= cl_i;
    end
    rd_cl_o <= cl_mem[raddr_i];
  end

endmodule

`default_nettype wire

/* design/kmeans_2d_clustering_top.sv */
// Top level of the 2D k-means clustering block: load control, clustering
// sequencer and result register. Depends on kmc_pkg, kmc_if, kmc_point_mem.
//
// Points are taken one per cycle while the block is loading; up to 32 are
// stored and later ones are dropped and flagged. The point marked final starts
// the run and the block is not ready until the last result word has been
// loaded into the output register. The run goes through one shared squaring
// multiplier, an x and a y accumulator and one bit-per-cycle divider: it
// seeds the centres from the first k points; each iteration assigns every
// point to its nearest centre, sums each centre's points and does two
// divisions per non-empty centre; output sends k centre words, then n point words.
`default_nettype none

module kmeans_2d_clustering_top import kmc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kmc_in_if.sink    in_i,
  kmc_cfg_if.sink   cfg_i,
  kmc_out_if.source out_o
);

  kmc_state_e state_q, state_d;

  logic [KW-1:0]   cc_q;
  logic [ItW-1:0]  ic_q;
  logic [CntW-1:0] n_q, n_d;
  logic            ovf_q, ovf_d;
  logic [KW-1:0]   k_q, k_d;
  logic [ItW-1:0]  iters_q, iters_d;
  logic [CntW-1:0] i_q, i_d;
  logic [KW-1:0]   j_q, j_d;
  logic [ItW-1:0]  it_q, it_d;
  logic            sel_q, sel_d;
  logic [DcW-1:0]  dc_q, dc_d;
  logic            ov_q, ov_d;

  logic [SqW-1:0]       sq_q, sq_d;
  logic [SqW:0]         dist_q, dist_d, best_q, best_d;
  logic [CidW-1:0]      bidx_q, bidx_d;
  logic signed [SumW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [CntW-1:0]      pc_q, pc_d;
  logic [IdxW:0]        rem_q, rem_d;
  logic [DivW-1:0]      dvd_q, dvd_d;
  logic                 neg_q, neg_d;
  kmc_rec_t             out_q, out_d;

  logic signed [CoordBits-1:0] cx_q [MaxClusters];
  logic signed [CoordBits-1:0] cy_q [MaxClusters];
  logic                        cwx_en, cwy_en;
  logic signed [CoordBits-1:0] cw_x, cw_y;

  logic                        pt_we, cl_we;
  logic [CidW-1:0]             cl_wdata;
  logic [IdxW-1:0]             raddr;
  logic signed [CoordBits-1:0] rd_x, rd_y;
  logic [CidW-1:0]             rd_cl;

  logic                        in_acc, slot_free;
  logic [CntW-1:0]             n_new;
  logic [KW-1:0]               kc;
  logic signed [CoordBits:0]   diff;
  logic [CoordBits:0]          dneg;
  logic [CoordBits-1:0]        mag;
  logic [SqW-1:0]              sq;
  logic                        better;
  logic [IdxW+1:0]             trial;
  logic                        ge;
  logic signed [SumW-1:0]      dsrc;
  logic [SumW-1:0]             dmag;
  logic [DivW-1:0]             qval;
  logic [CidW-1:0]             jc;

  assign in_acc    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == StLoad);
  assign cfg_i.ready = 1'b1;
  assign slot_free = !ov_q || out_o.ready;
  assign jc        = j_q[CidW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= ClusterCountReset;
      ic_q <= IterationCountReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CfgClusterCount:   cc_q <= cfg_i.data[KW-1:0];
        CfgIterationCount: ic_q <= cfg_i.data[ItW-1:0];
        default: ;
      endcase
    end
  end

  kmc_point_mem u_mem (
    .clk_i      (clk_i),
    .pt_we_i    (pt_we),
    .pt_waddr_i (n_q[IdxW-1:0]),
    .pt_x_i     (in_i.coord_x),
    .pt_y_i     (in_i.coord_y),
    .cl_we_i    (cl_we),
    .cl_waddr_i (i_q[IdxW-1:0]),
    .cl_i       (cl_wdata),
    .raddr_i    (raddr),
    .rd_x_o     (rd_x),
    .rd_y_o     (rd_y),
    .rd_cl_o    (rd_cl)
  );

  assign raddr = (state_q == StInitRd) ? IdxW'(j_q) : i_q[IdxW-1:0];

  // Shared squaring unit: x difference in one cycle, y difference in the next.
  always_comb begin
    if (state_q == StAsgDx) begin
      diff = {rd_x[CoordBits-1], rd_x} - {cx_q[jc][CoordBits-1], cx_q[jc]};
    end else begin
      diff = {rd_y[CoordBits-1], rd_y} - {cy_q[jc][CoordBits-1], cy_q[jc]};
    end
    dneg = (CoordBits+1)'(-diff);
    mag  = diff[CoordBits] ? dneg[CoordBits-1:0] : diff[CoordBits-1:0];
    sq   = mag * mag;
  end

  always_comb begin
    better = (j_q == '0) || (dist_q < best_q);
    trial  = {rem_q, dvd_q[DivW-1]};
    ge     = trial >= (IdxW+2)'(pc_q);
    dsrc   = sel_q ? sy_q : sx_q;
    dmag   = dsrc[SumW-1] ? SumW'(-dsrc) : SumW'(dsrc);
    qval   = neg_q ? DivW'(-dvd_q) : dvd_q;
    n_new  = (n_q < CntW'(MaxPoints)) ? n_q + 1'b1 : n_q;
    if (cc_q == '0) begin
      kc = KW'(1);
    end else if (cc_q > KW'(MaxClusters)) begin
      kc = KW'(MaxClusters);
    end else begin
      kc = cc_q;
    end
  end

  always_comb begin
    state_d = state_q;
    n_d = n_q;  ovf_d = ovf_q;  k_d = k_q;  iters_d = iters_q;
    i_d = i_q;  j_d = j_q;  it_d = it_q;  sel_d = sel_q;  dc_d = dc_q;
    ov_d = ov_q && !out_o.ready;
    sq_d = sq_q;  dist_d = dist_q;  best_d = best_q;  bidx_d = bidx_q;
    sx_d = sx_q;  sy_d = sy_q;  pc_d = pc_q;
    rem_d = rem_q;  dvd_d = dvd_q;  neg_d = neg_q;  out_d = out_q;
    pt_we = 1'b0;  cl_we = 1'b0;  cl_wdata = bidx_q;
    cwx_en = 1'b0;  cwy_en = 1'b0;  cw_x = rd_x;  cw_y = rd_y;

    case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (n_q < CntW'(MaxPoints)) begin
            pt_we = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          n_d = n_new;
          if (in_i.final_point) begin
            k_d     = (CntW'(kc) > n_new) ? KW'(n_new) : kc;
            iters_d = (ic_q == '0) ? ItW'(1) : ic_q;
            j_d     = '0;
            state_d = StInitRd;
          end
        end
      end
      StInitRd: state_d = StInitWr;
      StInitWr: begin
        cwx_en = 1'b1;
        cwy_en = 1'b1;
        if (j_q + 1'b1 == k_q) begin
          i_d = '0;  j_d = '0;  it_d = '0;
          state_d = StAsgRd;
        end else begin
          j_d = j_q + 1'b1;
          state_d = StInitRd;
        end
      end
      StAsgRd: begin
        j_d = '0;
        state_d = StAsgDx;
      end
      StAsgDx: begin
        sq_d = sq;
        state_d = StAsgDy;
      end
      StAsgDy: begin
        dist_d = {1'b0, sq_q} + {1'b0, sq};
        state_d = StAsgCmp;
      end
      StAsgCmp: begin
        if (better) begin
          best_d = dist_q;
          bidx_d = jc;
        end
        if (j_q + 1'b1 == k_q) begin
          cl_we    = 1'b1;
          cl_wdata = better ? jc : bidx_q;
          if (i_q + 1'b1 == n_q) begin
            i_d = '0;  j_d = '0;  sx_d = '0;  sy_d = '0;  pc_d = '0;
            state_d = StUpdRd;
          end else begin
            i_d = i_q + 1'b1;
            state_d = StAsgRd;
          end
        end else begin
          j_d = j_q + 1'b1;
          state_d = StAsgDx;
        end
      end
      StUpdRd: state_d = StUpdAcc;
      StUpdAcc: begin
        if (rd_cl == jc) begin
          sx_d = sx_q + SumW'(rd_x);
          sy_d = sy_q + SumW'(rd_y);
          pc_d = pc_q + 1'b1;
        end
        if (i_q + 1'b1 == n_q) begin
          state_d = StUpdChk;
        end else begin
          i_d = i_q + 1'b1;
          state_d = StUpdRd;
        end
      end
      StUpdChk: begin
        if (pc_q != '0) begin
          sel_d = 1'b0;
          state_d = StDivInit;
        end else begin
          state_d = StDivDone;
        end
      end
      StDivInit: begin
        neg_d = dsrc[SumW-1];
        dvd_d = dmag[DivW-1:0];
        rem_d = '0;
        dc_d  = DcW'(DivW);
        state_d = StDivStep;
      end
      StDivStep: begin
        rem_d = ge ? (IdxW+1)'(trial - (IdxW+2)'(pc_q)) : trial[IdxW:0];
        dvd_d = {dvd_q[DivW-2:0], ge};
        dc_d  = dc_q - 1'b1;
        if (dc_q == DcW'(1)) begin
          state_d = StDivDone;
        end
      end
      StDivDone: begin
        cw_x = qval[CoordBits-1:0];
        cw_y = qval[CoordBits-1:0];
        if (pc_q != '0 && !sel_q) begin
          cwx_en = 1'b1;
          sel_d = 1'b1;
          state_d = StDivInit;
        end else begin
          cwy_en = (pc_q != '0);
          i_d = '0;  sx_d = '0;  sy_d = '0;  pc_d = '0;
          if (j_q + 1'b1 == k_q) begin
            j_d = '0;
            if (it_q + 1'b1 == iters_q) begin
              state_d = StOutC;
            end else begin
              it_d = it_q + 1'b1;
              state_d = StAsgRd;
            end
          end else begin
            j_d = j_q + 1'b1;
            state_d = StUpdRd;
          end
        end
      end
      StOutC: begin
        if (slot_free) begin
          ov_d = 1'b1;
          out_d.record_kind    = KindCenter;
          out_d.record_index   = 5'(j_q);
          out_d.cluster_id     = jc;
          out_d.out_x          = cx_q[jc];
          out_d.out_y          = cy_q[jc];
          out_d.dropped_points = ovf_q;
          out_d.run_end        = 1'b0;
          if (j_q + 1'b1 == k_q) begin
            i_d = '0;
            state_d = StOutRd;
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      StOutRd: state_d = StOutPt;
      StOutPt: begin
        if (slot_free) begin
          ov_d = 1'b1;
          out_d.record_kind    = KindPoint;
          out_d.record_index   = 5'(i_q);
          out_d.cluster_id     = rd_cl;
          out_d.out_x          = rd_x;
          out_d.out_y          = rd_y;
          out_d.dropped_points = ovf_q;
          out_d.run_end        = (i_q + 1'b1 == n_q);
          if (i_q + 1'b1 == n_q) begin
            n_d = '0;
            ovf_d = 1'b0;
            state_d = StLoad;
          end else begin
            i_d = i_q + 1'b1;
            state_d = StOutRd;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      n_q <= '0;  ovf_q <= 1'b0;  k_q <= '0;  iters_q <= '0;
      i_q <= '0;  j_q <= '0;  it_q <= '0;  sel_q <= 1'b0;  dc_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q <= n_d;  ovf_q <= ovf_d;  k_q <= k_d;  iters_q <= iters_d;
      i_q <= i_d;  j_q <= j_d;  it_q <= it_d;  sel_q <= sel_d;  dc_q <= dc_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;  dist_q <= dist_d;  best_q <= best_d;  bidx_q <= bidx_d;
    sx_q <= sx_d;  sy_q <= sy_d;  pc_q <= pc_d;
    rem_q <= rem_d;  dvd_q <= dvd_d;  neg_q <= neg_d;  out_q <= out_d;
    if (cwx_en) begin
      cx_q[jc] <= cw_x;
    end
    if (cwy_en) begin
      cy_q[jc] <= cw_y;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.record_kind    = out_q.record_kind;
  assign out_o.record_index   = out_q.record_index;
  assign out_o.cluster_id     = out_q.cluster_id;
  assign out_o.out_x          = out_q.out_x;
  assign out_o.out_y          = out_q.out_y;
  assign out_o.dropped_points = out_q.dropped_points;
  assign out_o.run_end        = out_q.run_end;

  // A run never starts without at least one stored point and one centre.
  a_run_has_points : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> (n_q != '0) && (k_q != '0) && (CntW'(k_q) <= n_q))
    else $error("clustering run with no points or too many centres");

  a_assign_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cl_we |-> (KW'(cl_wdata) < k_q))
    else $error("point assigned to a centre beyond the cluster count");

  a_div_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivStep) |-> (dc_q != '0) && (pc_q != '0))
    else $error("divider stepping with no count");

  a_last_word_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StOutPt && slot_free && i_q + 1'b1 == n_q) |=> (state_q == StLoad) && ov_q
      && out_q.run_end)
    else $error("last result word not marked or block not back to loading");

endmodule

`default_nettype wire

/* dv/kmeans_2d_clustering_top_test.sv */
// Testbench for the 2D k-means clustering block: directed and random point sets
// are checked word by word against a predictor kept in this file.
// Depends on kmc_pkg, kmc_if and the kmeans_2d_clustering_top design.
`default_nettype none

module kmeans_2d_clustering_top_test import kmc_pkg::*;;

  localparam int QuietLimit = 1_500_000;
  localparam int SettleCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kmc_in_if  pts ();
  kmc_cfg_if cfg ();
  kmc_out_if res ();

  kmeans_2d_clustering_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pts),
    .cfg_i  (cfg),
    .out_o  (res)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state.
  logic [KW-1:0]  k_reg;
  logic [ItW-1:0] iter_reg;
  longint         px [MaxPoints];
  longint         py [MaxPoints];
  int             member [MaxPoints];
  longint         cx [MaxClusters];
  longint         cy [MaxClusters];
  int             n_loaded;
  bit             overflow;
  kmc_rec_t       expected_records [$];

  int  mismatches = 0;
  int  items_sent = 0;
  bit  gaps_on = 1'b1;
  int  hold_req = 0;
  int  quiet = 0;

  task automatic cluster_points();
    int k, iters, c, best;
    longint d, bd, sx, sy;
    kmc_rec_t r;
    k = k_reg;
    iters = iter_reg;
    if (k == 0) k = 1;
    if (k > MaxClusters) k = MaxClusters;
    if (k > n_loaded) k = n_loaded;
    if (iters == 0) iters = 1;
    for (int j = 0; j < k; j++) begin
      cx[j] = px[j];
      cy[j] = py[j];
    end
    for (int it = 0; it < iters; it++) begin
      for (int i = 0; i < n_loaded; i++) begin
        best = 0;
        bd = (px[i] - cx[0]) * (px[i] - cx[0]) + (py[i] - cy[0]) * (py[i] - cy[0]);
        for (int j = 1; j < k; j++) begin
          d = (px[i] - cx[j]) * (px[i] - cx[j]) + (py[i] - cy[j]) * (py[i] - cy[j]);
          if (d < bd) begin
            bd = d;
            best = j;
          end
        end
        member[i] = best;
      end
      for (int j = 0; j < k; j++) begin
        sx = 0;
        sy = 0;
        c = 0;
        for (int i = 0; i < n_loaded; i++) begin
          if (member[i] == j) begin
            sx += px[i];
            sy += py[i];
            c++;
          end
        end
        if (c != 0) begin
          cx[j] = sx / c;
          cy[j] = sy / c;
        end
      end
    end
    for (int j = 0; j < k + n_loaded; j++) begin
      r.record_kind    = (j < k) ? KindCenter : KindPoint;
      r.record_index   = (j < k) ? 5'(j) : 5'(j - k);
      r.cluster_id     = (j < k) ? 3'(j) : 3'(member[j - k]);
      r.out_x          = (j < k) ? CoordBits'(cx[j]) : CoordBits'(px[j - k]);
      r.out_y          = (j < k) ? CoordBits'(cy[j]) : CoordBits'(py[j - k]);
      r.dropped_points = overflow;
      r.run_end        = (j == k + n_loaded - 1);
      expected_records = {expected_records, r};
    end
    n_loaded = 0;
    overflow = 1'b0;
  endtask

  task automatic absorb_point(logic signed [CoordBits-1:0] x, logic signed [CoordBits-1:0] y,
                              logic fin);
    if (n_loaded < MaxPoints) begin
      px[n_loaded] = x;
      py[n_loaded] = y;
      n_loaded++;
    end else begin
      overflow = 1'b1;
    end
    if (fin) cluster_points();
  endtask

  task automatic send_point(logic signed [CoordBits-1:0] x, logic signed [CoordBits-1:0] y,
                            logic fin);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      pts.valid = 1'b0;
      repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    pts.valid = 1'b1;
    pts.coord_x = x;
    pts.coord_y = y;
    pts.final_point = fin;
    @(posedge clk_i);
    while (!pts.ready) @(posedge clk_i);
    absorb_point(x, y, fin);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    pts.valid = 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    if (idx == CfgClusterCount) k_reg = val[KW-1:0];
    else if (idx == CfgIterationCount) iter_reg = val;
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  function automatic logic [CoordBits-1:0] rand_coord(logic [CoordBits-1:0] base);
    case ($urandom_range(0, 3))
      0: return CoordBits'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return CoordBits'(base + $urandom_range(0, 1023) - 512);
    endcase
  endfunction

  task automatic send_set(int n);
    logic [CoordBits-1:0] bx, by;
    bx = CoordBits'($urandom);
    by = CoordBits'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        bx = CoordBits'($urandom);
        by = CoordBits'($urandom);
      end
      send_point(rand_coord(bx), rand_coord(by), i == n - 1);
    end
  endtask

  task automatic test_reset_settings();
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(-16'sh8000, -16'sh8000, 1'b0);
    send_point(16'sh0000, 16'sh0000, 1'b0);
    send_point(16'sh0001, -16'sh0001, 1'b0);
    send_point(16'sh7fff, -16'sh8000, 1'b1);
    send_point(16'sh0100, 16'sh0100, 1'b1);
    send_point(16'sh0005, 16'sh0005, 1'b0);
    send_point(16'sh0005, 16'sh0005, 1'b0);
    send_point(16'sh0005, 16'sh0005, 1'b1);
    drain_results();
  endtask

  task automatic test_register_extremes();
    write_reg(CfgClusterCount, 8'd0);
    write_reg(CfgIterationCount, 8'd0);
    send_set(4);
    drain_results();
    write_reg(CfgClusterCount, 8'd15);
    write_reg(CfgIterationCount, 8'd255);
    write_reg(2'd2, 8'hff);
    write_reg(2'd3, 8'h00);
    send_set(10);
    drain_results();
    write_reg(CfgClusterCount, 8'd8);
    write_reg(CfgIterationCount, 8'd1);
    send_set(8);
    send_set(3);
    drain_results();
  endtask

  task automatic test_capacity_overflow();
    write_reg(CfgClusterCount, 8'd4);
    write_reg(CfgIterationCount, 8'd3);
    send_set(34);
    send_set(32);
    send_set(2);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    @(posedge clk_i);
    hold_req = 150;
    send_set(6);
    send_set(12);
    drain_results();
  endtask

  task automatic test_random_sets(int upto);
    while (items_sent < upto) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_results();
        if ($urandom_range(0, 5) == 0) write_reg(CfgClusterCount, CfgDataW'($urandom_range(0, 15)));
        else write_reg(CfgClusterCount, CfgDataW'($urandom_range(1, 8)));
        write_reg(CfgIterationCount, CfgDataW'($urandom_range(0, 12)));
      end
      send_set(($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 12));
    end
    drain_results();
  endtask

  // Result sink: random stall bursts, plus a long hold when one is requested.
  initial begin
    int stall_left;
    stall_left = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_req--;
        res.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        res.ready = 1'b0;
      end else begin
        res.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    kmc_rec_t got, want;
    if (rst_ni && res.valid && res.ready) begin
      got.record_kind    = res.record_kind;
      got.record_index   = res.record_index;
      got.cluster_id     = res.cluster_id;
      got.out_x          = res.out_x;
      got.out_y          = res.out_y;
      got.dropped_points = res.dropped_points;
      got.run_end        = res.run_end;
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        mismatches++;
      end else begin
        want = expected_records.pop_front();
        if (got.record_kind !== want.record_kind || got.record_index !== want.record_index ||
            got.cluster_id !== want.cluster_id || got.out_x !== want.out_x ||
            got.out_y !== want.out_y || got.dropped_points !== want.dropped_points ||
            got.run_end !== want.run_end) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pts.valid && pts.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QuietLimit) begin
      $display("[kmeans_2d_clustering_top] ERROR");
      $finish;
    end
  end

  initial begin
    pts.valid = 1'b0;
    pts.coord_x = '0;
    pts.coord_y = '0;
    pts.final_point = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    k_reg = ClusterCountReset;
    iter_reg = IterationCountReset;
    n_loaded = 0;
    overflow = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_settings();
    test_register_extremes();
    test_capacity_overflow();
    test_output_backpressure();
    test_random_sets(320);
    gaps_on = 1'b0;
    test_random_sets(400);
    if (expected_records.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time,
               expected_records.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[kmeans_2d_clustering_top] OK");
    end else begin
      $display("[kmeans_2d_clustering_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
design/kmc_pkg.sv
design/kmc_if.sv
design/kmc_point_mem.sv
design/kmeans_2d_clustering_top.sv
dv/kmeans_2d_clustering_top_test.sv
